/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, off while reset is low.
`define GTW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising clock edge, checked during reset too.
`define GTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/gtw_pkg.sv */
// ----------------------------------------------------------------------------
// gtw_pkg
// Constants, register map and exponential table of the time-window taper.
// ----------------------------------------------------------------------------
package gtw_pkg;

	// Highest sample index taken is 2^INDEX_BITS-1.
	localparam int unsigned INDEX_BITS = 16;

	// Configuration register map, word index at paddr[4:2].
	typedef enum logic [2:0] {
		REG_PERIOD    = 3'd0,
		REG_GAMMA     = 3'd1,
		REG_WIN_PLUS  = 3'd2,
		REG_WIN_MINUS = 3'd3,
		REG_PER_TRACE = 3'd4
	} reg_idx_t;

	localparam logic [31:0] PERIOD_RESET = 32'd1049;

	// Exponential product: one optional factor exp(-2^(b-10)) per bit of xr.
	localparam int unsigned EXP_BITS = 14;
	localparam logic [24:0] ONE_Q24  = 25'd16777216;
	localparam logic [48:0] HALF_Q24 = 49'd8388608;

	localparam logic [23:0] EXP_FACTOR [EXP_BITS] = '{
		24'd16760841, 24'd16744480, 24'd16711807, 24'd16646655, 24'd16517109,
		24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
		24'd6171993,  24'd2270549,  24'd307285,   24'd5628
	};

	// Pipeline layout: taper ready at TAPER_STG, result register at LAST_STG.
	localparam int unsigned TAPER_STG = 20;
	localparam int unsigned LAST_STG  = 24;

endpackage

/* src/gtw_taper_lane.sv */
// ----------------------------------------------------------------------------
// gtw_taper_lane
// Pipelined Q1.15 taper exp(-gamma*d^2) from a distance d, stages 3 to 20.
// ----------------------------------------------------------------------------
module gtw_taper_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] gamma,
	input  logic [31:0] span,     // |d|, Q12.20 seconds, stage 2 register
	output logic [15:0] taper     // Q1.15, stage 20 register
);

	logic [63:0] sq_s3;
	logic [63:0] mlo_s4;
	logic [39:0] mhi_s4;
	logic [13:0] xr_s5;
	logic        zero_s5;
	logic [24:0] acc_s  [gtw_pkg::EXP_BITS];
	logic [13:0] xr_e   [gtw_pkg::EXP_BITS];
	logic        zero_e [gtw_pkg::EXP_BITS];
	logic [15:0] taper_s20;

	logic [40:0] top_sum;
	logic [19:0] x_q16;
	logic [20:0] x_rnd;
	logic [24:0] acc_nxt [gtw_pkg::EXP_BITS];
	logic [25:0] taper_rnd;

	// Product of a^2>>24 and gamma, upper half added above bit 32.
	always_comb begin
		top_sum = {1'b0, mhi_s4} + {9'b0, mlo_s4[63:32]};
		x_q16   = {top_sum[3:0], mlo_s4[31:16]};
		x_rnd   = {1'b0, x_q16} + 21'd32;
	end

	always_comb begin
		logic [24:0] acc_in;
		logic [48:0] prod;
		logic [13:0] xr_in;
		for (int b = 0; b < gtw_pkg::EXP_BITS; b++) begin
			acc_in = (b == 0) ? gtw_pkg::ONE_Q24 : acc_s[(b == 0) ? 0 : b - 1];
			xr_in  = (b == 0) ? xr_s5 : xr_e[(b == 0) ? 0 : b - 1];
			prod   = 49'(acc_in) * 49'(gtw_pkg::EXP_FACTOR[b]) + gtw_pkg::HALF_Q24;
			acc_nxt[b] = xr_in[b] ? prod[48:24] : acc_in;
		end
	end

	assign taper_rnd = {1'b0, acc_s[gtw_pkg::EXP_BITS-1]} + 26'd256;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= 64'(span) * 64'(span);
			mlo_s4  <= 64'(sq_s3[55:24]) * 64'(gamma);
			mhi_s4  <= 40'(sq_s3[63:56]) * 40'(gamma);
			xr_s5   <= x_rnd[19:6];
			// Clamp to zero once the exponent reaches 16.
			zero_s5 <= (|top_sum[40:4]) | x_rnd[20];
			for (int b = 0; b < gtw_pkg::EXP_BITS; b++) begin
				acc_s[b]  <= acc_nxt[b];
				xr_e[b]   <= (b == 0) ? xr_s5 : xr_e[(b == 0) ? 0 : b - 1];
				zero_e[b] <= (b == 0) ? zero_s5 : zero_e[(b == 0) ? 0 : b - 1];
			end
			taper_s20 <= zero_e[gtw_pkg::EXP_BITS-1] ? 16'd0 : taper_rnd[24:9];
		end
	end

	assign taper = taper_s20;

endmodule

/* src/gaussian_time_window_taper_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_time_window_taper_unit
// Gaussian taper of seismic samples outside a window around the picked arrival.
// ----------------------------------------------------------------------------
// Channel  | Dir | Signals                         | Content
// s_       | in  | tvalid tready tdata[143:0]      | sample, index, pick, windows
// m_       | out | tvalid tready tdata[31:0] tuser | tapered sample, taper flags
// apb      | in  | psel penable pwrite paddr ...   | five config registers
//
// One item per cycle while no result is held; 24 register stages: the 14-stage
// exponential product chain plus the time, square and scaling stages.
// Reset clears all stage valid bits and loads register reset values.
// A held result with m_tready low freezes every stage and drops s_tready.
// ----------------------------------------------------------------------------
module gaussian_time_window_taper_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample_value[31:0], sample_index[47:32], pick_time[79:48],
	// trace_plus[111:80], trace_minus[143:112]
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// windowed_value[31:0]
	output logic [31:0]  m_tdata,
	// taper_applied[1:0]
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int unsigned TS = gtw_pkg::TAPER_STG;
	localparam int unsigned LS = gtw_pkg::LAST_STG;

	logic [31:0] period_q;
	logic [31:0] gamma_q;
	logic [31:0] win_plus_q;
	logic [31:0] win_minus_q;
	logic        per_trace_q;

	logic        adv;
	logic        vld_s  [1:LS];
	logic [31:0] mag_s  [1:TS+1];
	logic        neg_s  [1:LS];
	logic [1:0]  flag_s [2:LS];

	logic        rng_s1;
	logic [47:0] prod_s1;
	logic [32:0] pp_s1;
	logic [33:0] pmin_s1;
	logic [31:0] a_late_s2;
	logic [31:0] a_early_s2;
	logic [15:0] te_s21;
	logic [15:0] te_s22;
	logic [47:0] p1_s21;
	logic [31:0] m1_s22;
	logic [31:0] m1_s23;
	logic [47:0] p2_s23;
	logic [31:0] out_s24;

	logic [31:0] in_value;
	logic [15:0] in_index;
	logic [31:0] in_pick;
	logic [31:0] plus_sel;
	logic [31:0] minus_sel;
	logic [31:0] time_s2;
	logic        late;
	logic        early;
	logic [15:0] taper_late;
	logic [15:0] taper_early;
	logic [47:0] r1_sum;
	logic [47:0] r2_sum;
	logic [31:0] m2;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= gtw_pkg::PERIOD_RESET;
			gamma_q     <= 32'd0;
			win_plus_q  <= 32'd0;
			win_minus_q <= 32'd0;
			per_trace_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				gtw_pkg::REG_PERIOD:    period_q    <= pwdata;
				gtw_pkg::REG_GAMMA:     gamma_q     <= pwdata;
				gtw_pkg::REG_WIN_PLUS:  win_plus_q  <= pwdata;
				gtw_pkg::REG_WIN_MINUS: win_minus_q <= pwdata;
				gtw_pkg::REG_PER_TRACE: per_trace_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			gtw_pkg::REG_PERIOD:    prdata = period_q;
			gtw_pkg::REG_GAMMA:     prdata = gamma_q;
			gtw_pkg::REG_WIN_PLUS:  prdata = win_plus_q;
			gtw_pkg::REG_WIN_MINUS: prdata = win_minus_q;
			gtw_pkg::REG_PER_TRACE: prdata = {31'd0, per_trace_q};
			default:                prdata = 32'd0;
		endcase
	end

	// Whole pipeline moves unless a finished result is waiting.
	assign adv      = !vld_s[LS] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LS; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_tvalid;
			for (int i = 2; i <= LS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// Stage 1: index times period, window edges around the pick
	assign in_value  = s_tdata[31:0];
	assign in_index  = s_tdata[47:32];
	assign in_pick   = s_tdata[79:48];
	assign plus_sel  = per_trace_q ? s_tdata[111:80]  : win_plus_q;
	assign minus_sel = per_trace_q ? s_tdata[143:112] : win_minus_q;

	// Stage 2: saturated time, window tests, distances
	assign time_s2 = (|prod_s1[47:32]) ? 32'hFFFF_FFFF : prod_s1[31:0];
	assign late    = {1'b0, time_s2} >= pp_s1;
	assign early   = $signed({2'b00, time_s2}) <= $signed(pmin_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			rng_s1   <= (in_index > 16'd1) &&
				((32'(in_index) >> gtw_pkg::INDEX_BITS) == 32'd0);
			prod_s1  <= 48'(in_index) * 48'(period_q);
			pp_s1    <= {1'b0, in_pick} + {1'b0, plus_sel};
			pmin_s1  <= {2'b00, in_pick} - {2'b00, minus_sel};
			neg_s[1] <= in_value[31];
			mag_s[1] <= in_value[31] ? (32'd0 - in_value) : in_value;

			flag_s[2]  <= {rng_s1 & early, rng_s1 & late};
			a_late_s2  <= time_s2 - pp_s1[31:0];
			a_early_s2 <= pmin_s1[31:0] - time_s2;

			for (int i = 2; i <= TS + 1; i++) mag_s[i] <= mag_s[i-1];
			for (int i = 2; i <= LS; i++) neg_s[i] <= neg_s[i-1];
			for (int i = 3; i <= LS; i++) flag_s[i] <= flag_s[i-1];
		end
	end

	// Stages 3 to 20: one taper lane per window side
	gtw_taper_lane u_late (
		.clk   (clk),
		.en    (adv),
		.gamma (gamma_q),
		.span  (a_late_s2),
		.taper (taper_late)
	);

	gtw_taper_lane u_early (
		.clk   (clk),
		.en    (adv),
		.gamma (gamma_q),
		.span  (a_early_s2),
		.taper (taper_early)
	);

	// Stages 21 to 24: late taper first, early taper on its result
	assign r1_sum = p1_s21 + 48'd16384;
	assign r2_sum = p2_s23 + 48'd16384;
	assign m2     = flag_s[LS-1][1] ? r2_sum[46:15] : m1_s23;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s21  <= 48'(mag_s[TS]) * 48'(taper_late);
			te_s21  <= taper_early;
			m1_s22  <= flag_s[TS+1][0] ? r1_sum[46:15] : mag_s[TS+1];
			te_s22  <= te_s21;
			p2_s23  <= 48'(m1_s22) * 48'(te_s22);
			m1_s23  <= m1_s22;
			out_s24 <= neg_s[LS-1] ? (32'd0 - m2) : m2;
		end
	end

	assign m_tvalid = vld_s[LS];
	assign m_tdata  = out_s24;
	assign m_tuser  = flag_s[LS];

endmodule

/* src/gtw_checker.sv */
// ----------------------------------------------------------------------------
// gtw_checker
// Port-level checks of the time-window taper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtw_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata,
	input logic [1:0]   m_tuser,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic [4:0]   paddr,
	input logic [31:0]  pwdata,
	input logic [31:0]  prdata,
	input logic         pready
);

	`GTW_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`GTW_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_tvalid |-> s_tready, "input blocked with no result held")

	`GTW_ASSERT(a_ready_only_on_stall, clk, arst_n, !s_tready |-> m_tvalid && !m_tready, "input blocked without output stall")

	`GTW_ASSERT(a_period_readback, clk, arst_n, psel && penable && pwrite && pready && paddr[4:2] == gtw_pkg::REG_PERIOD |=> paddr[4:2] != gtw_pkg::REG_PERIOD || prdata == $past(pwdata), "period register readback mismatch")

endmodule

bind gaussian_time_window_taper_unit gtw_checker u_gtw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);

/* tb/gaussian_time_window_taper_unit_tb.sv */
// ----------------------------------------------------------------------------
// gaussian_time_window_taper_unit_tb
// Self-checking bench for the time-window taper. A scoreboard predicts the
// tapered sample and flags of every accepted item with its own copy of the
// registers. Items are directed corner cases, then random traces aimed at the
// window edges. Both stream sides idle at random, and registers change only
// between phases.
// ----------------------------------------------------------------------------
module gaussian_time_window_taper_unit_tb;

	// Register indexes past the map; writes there must be dropped.
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam int IDLE_LIMIT      = 2000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 125;

	typedef struct {
		logic signed [31:0] value;
		logic [15:0]        index;
		logic [31:0]        pick;
		logic [31:0]        plus;
		logic [31:0]        minus;
	} trace_sample_t;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  flags;
	} taper_result_t;

	class taper_scoreboard;
		logic [31:0]   period;
		logic [31:0]   damping;
		logic [31:0]   win_plus;
		logic [31:0]   win_minus;
		logic          per_trace;
		logic [23:0]   exp_step [14];
		taper_result_t pending_results [$];
		int            errors;
		int            checked;

		function new();
			period    = 32'd1049;
			damping   = '0;
			win_plus  = '0;
			win_minus = '0;
			per_trace = 1'b0;
			errors    = 0;
			checked   = 0;
			exp_step  = '{24'd16760841, 24'd16744480, 24'd16711807, 24'd16646655,
				24'd16517109, 24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109,
				24'd10175896, 24'd6171993, 24'd2270549, 24'd307285, 24'd5628};
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				gtw_pkg::REG_PERIOD:    period    = val;
				gtw_pkg::REG_GAMMA:     damping   = val;
				gtw_pkg::REG_WIN_PLUS:  win_plus  = val;
				gtw_pkg::REG_WIN_MINUS: win_minus = val;
				gtw_pkg::REG_PER_TRACE: per_trace = val[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] sample_time(logic [15:0] idx);
			logic [63:0] t;
			t = {48'd0, idx} * {32'd0, period};
			if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
			return t;
		endfunction

		// exp(-gamma*a^2) in Q1.15 from the product of exp(-2^(b-10)) steps.
		function logic [15:0] gauss_taper(logic [63:0] a, logic [31:0] g);
			logic [63:0] sq, lim, x, xr, acc;
			if (g == '0) return 16'd32768;
			if (a >= 64'h1_0000_0000) return 16'd0;
			sq  = (a * a) >> 24;
			lim = (64'd1 << 36) / {32'd0, g};
			if (sq > lim) return 16'd0;
			x  = (sq * {32'd0, g}) >> 16;
			xr = (x + 64'd32) >> 6;
			if (xr >= 64'd16384) return 16'd0;
			acc = 64'd1 << 24;
			for (int b = 0; b < 14; b++)
				if (xr[b]) acc = (acc * {40'd0, exp_step[b]} + (64'd1 << 23)) >> 24;
			return 16'((acc + 64'd256) >> 9);
		endfunction

		// Round half away from zero, sign restored.
		function logic [31:0] scale_sample(logic [31:0] v, logic [15:0] tp);
			logic [63:0] mag, r;
			mag = v[31] ? -longint'(signed'(v)) : longint'(signed'(v));
			r   = (mag * {48'd0, tp} + 64'd16384) >> 15;
			return v[31] ? -r[31:0] : r[31:0];
		endfunction

		function taper_result_t predict_taper(trace_sample_t s);
			taper_result_t r;
			longint tm, pk, wp, wm, d;
			logic [63:0] a;
			r.value = s.value;
			r.flags = 2'b00;
			pk = longint'({32'd0, s.pick});
			wp = longint'({32'd0, per_trace ? s.plus : win_plus});
			wm = longint'({32'd0, per_trace ? s.minus : win_minus});
			if (s.index >= 16'd2 &&
				32'(s.index) <= (32'd1 << gtw_pkg::INDEX_BITS) - 1) begin
				tm = longint'(sample_time(s.index));
				if (tm >= pk + wp) begin
					d = tm - pk - wp;
					a = d;
					r.value = scale_sample(r.value, gauss_taper(a, damping));
					r.flags[0] = 1'b1;
				end
				// early taper works on the late-tapered value
				if (tm <= pk - wm) begin
					d = tm - pk + wm;
					a = -d;
					r.value = scale_sample(r.value, gauss_taper(a, damping));
					r.flags[1] = 1'b1;
				end
			end
			return r;
		endfunction

		function void note_sample(trace_sample_t s);
			pending_results.push_back(predict_taper(s));
		endfunction

		function void report(string msg);
			if (errors < 100) $display("mismatch: %s", msg);
			errors++;
		endfunction

		function void check_result(logic [31:0] val, logic [1:0] flags);
			taper_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result %h/%0d arrived with nothing pending", val, flags));
				return;
			end
			want = pending_results.pop_front();
			if (val !== want.value)
				report($sformatf("item %0d windowed_value %h, want %h", checked, val,
					want.value));
			if (flags !== want.flags)
				report($sformatf("item %0d taper_applied %0d, want %0d", checked, flags,
					want.flags));
			checked++;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// sample_value, sample_index, pick_time, trace_plus, trace_minus
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// windowed_value
	logic [31:0]  m_tdata;
	// taper_applied
	logic [1:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	taper_scoreboard sb = new();
	int send_calm = 0;
	int idle_cycles = 0;

	gaussian_time_window_taper_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Result side: random stall per item, with calm stretches.
	initial begin
		int stall;
		int calm;
		calm = 0;
		m_tready = 1'b0;
		forever begin
			if (calm > 0) begin
				stall = 0;
				calm--;
			end else begin
				stall = $urandom_range(0, 10);
				if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 60);
			end
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_sample(input trace_sample_t it);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 60);
		end
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {it.minus, it.plus, it.pick, it.index, it.value};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(it);
	endtask

	// Stop sending, drain every pending result, then let the pipe run empty.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (gtw_pkg::LAST_STG + 8) @(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] per, input logic [31:0] g,
		input logic [31:0] wp, input logic [31:0] wm, input logic [31:0] pt);
		write_reg(gtw_pkg::REG_PERIOD, per);
		write_reg(gtw_pkg::REG_GAMMA, g);
		write_reg(gtw_pkg::REG_WIN_PLUS, wp);
		write_reg(gtw_pkg::REG_WIN_MINUS, wm);
		write_reg(gtw_pkg::REG_PER_TRACE, pt);
	endtask

	function automatic trace_sample_t mk_sample(logic [31:0] v, logic [15:0] i,
		logic [31:0] p, logic [31:0] pl, logic [31:0] mi);
		trace_sample_t s;
		s.value = v;
		s.index = i;
		s.pick  = p;
		s.plus  = pl;
		s.minus = mi;
		return s;
	endfunction

	// Place the pick so the sample lands near a window edge most of the time.
	function automatic trace_sample_t random_sample();
		trace_sample_t s;
		longint tm, pk, wp, wm, off;
		int k;
		s.value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) - 32 : $urandom;
		case ($urandom_range(0, 9))
			0:       s.index = 16'($urandom_range(0, 1));
			1, 2, 3: s.index = 16'($urandom);
			default: s.index = 16'($urandom_range(2, 2000));
		endcase
		s.plus  = $urandom >> $urandom_range(0, 31);
		s.minus = $urandom >> $urandom_range(0, 31);
		wp = longint'({32'd0, sb.per_trace ? s.plus : sb.win_plus});
		wm = longint'({32'd0, sb.per_trace ? s.minus : sb.win_minus});
		tm = longint'(sb.sample_time(s.index));
		k = $urandom_range(0, 31);
		off = longint'({32'd0, $urandom}) & ((longint'(1) << k) - 1);
		case ($urandom_range(0, 4))
			0, 1:    pk = tm - wp - off;
			2, 3:    pk = tm + wm + off;
			default: pk = longint'({32'd0, $urandom});
		endcase
		if (pk < 0 || pk > 64'sh0_FFFF_FFFF) pk = longint'({32'd0, $urandom});
		s.pick = pk[31:0];
		return s;
	endfunction

	task automatic random_setting();
		logic [31:0] per, g, wp, wm, pt;
		case ($urandom_range(0, 7))
			0:       per = '0;
			1:       per = 32'd1;
			2:       per = '1;
			3:       per = $urandom;
			default: per = $urandom_range(1, 65536);
		endcase
		case ($urandom_range(0, 7))
			0:       g = '0;
			1:       g = 32'd1;
			2:       g = '1;
			default: g = $urandom >> $urandom_range(0, 31);
		endcase
		wp = ($urandom_range(0, 5) == 0) ? '1 : $urandom >> $urandom_range(4, 31);
		wm = ($urandom_range(0, 5) == 0) ? '0 : $urandom >> $urandom_range(4, 31);
		// upper bits are junk; only bit 0 counts
		pt = $urandom;
		write_all(per, g, wp, wm, pt);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero gamma and zero windows, sample must pass untouched.
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd0, 32'd0, '1, '1));
		send_sample(mk_sample(32'h8000_0000, 16'd1, 32'd0, '0, '0));
		send_sample(mk_sample(-32'sd12345, 16'd2, 32'd2098, '0, '0));
		send_sample(mk_sample(32'd1000, 16'd65535, 32'd0, '0, '0));
		send_sample(mk_sample(32'hFFFF_FFFF, 16'd2, 32'hFFFF_FFFF, '0, '0));
		drain();

		// Writes past the map must not disturb anything.
		for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
			write_reg(3'(r), $urandom);

		// 1 ms period, gamma 100, windows 0.1 s after and 0.05 s before the pick.
		write_all(32'd1049, 32'h0064_0000, 32'd104858, 32'd52429, 32'hFFFF_FFFE);
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd1000, 32'd944142, '0, '0));
		send_sample(mk_sample(32'h8000_0000, 16'd1000, 32'd1101429, '0, '0));
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd1000, 32'd891713, '0, '0));
		send_sample(mk_sample(-32'sd1000000, 16'd1000, 32'd1206287, '0, '0));
		send_sample(mk_sample(32'd1, 16'd1000, 32'd924142, '0, '0));
		send_sample(mk_sample(32'h8000_0000, 16'd65535, 32'd0, '0, '0));
		send_sample(mk_sample(32'd12345, 16'd1000, 32'd1000000, '0, '0));
		send_sample(mk_sample(32'd5, 16'd65535, 32'd68746215, '1, '1));
		drain();

		// Per-trace windows, zero period, smallest nonzero gamma.
		write_all(32'd0, 32'd1, '1, '1, 32'd1);
		send_sample(mk_sample(32'd777, 16'd2, 32'd0, '0, '0));
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd500, '1, '1, '0));
		send_sample(mk_sample(-32'sd3, 16'd3, 32'd0, '0, '1));
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd7, 32'd1 << 20, '0, 32'd1 << 20));
		drain();

		// Saturated sample time, largest gamma and windows.
		write_all('1, '1, '1, '1, 32'd0);
		send_sample(mk_sample(32'h7FFF_FFFF, 16'd2, 32'd0, '0, '0));
		send_sample(mk_sample(32'd7, 16'd65535, 32'hFFFF_FFFE, '0, '0));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			random_setting();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off mid-phase until the pipe is empty
				if (ph[0] && n == ITEMS_PER_PHASE / 2) drain();
				send_sample(random_sample());
			end
			drain();
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
